// File: src/kalman_angle_bias_filter_core_defines.svh
// Assertion macros for the angle/bias filter core.
// Used by the top level only; no other dependencies.
`ifndef KALMAN_ANGLE_BIAS_FILTER_CORE_DEFINES_SVH
`define KALMAN_ANGLE_BIAS_FILTER_CORE_DEFINES_SVH
// check that a condition implies a consequence in the same cycle
`define KABF_ASSERT_SAME(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);
// check that a condition implies a consequence in the next cycle
`define KABF_ASSERT_NEXT(lbl, clk, rst, cond, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);
`endif

// File: src/kabf_pkg.sv
// Shared types and constants for the angle/bias filter core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package kabf_pkg;
   localparam int NoiseW = 24;
   localparam logic [1:0] CsrAngleNoise = 2'd0;
   localparam logic [1:0] CsrBiasNoise  = 2'd1;
   localparam logic [1:0] CsrMeasNoise  = 2'd2;
   localparam logic [23:0] AngleNoiseRst = 24'd16777;
   localparam logic [23:0] BiasNoiseRst  = 24'd50332;
   localparam logic [23:0] MeasNoiseRst  = 24'd503316;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RATE, ST_ANG, ST_T, ST_INNER, ST_N00, ST_N11,
      ST_DIVST, ST_DIV0, ST_DIV1, ST_Y,
      ST_CA, ST_CB, ST_C00, ST_C01, ST_C10, ST_C11, ST_DONE
   } state_type;

   // shared multiplier control: a operand, b operand, rounding shift select
   typedef struct packed {
      logic signed [33:0] a;
      logic signed [32:0] b;
      logic               sh24;
   } mul_req_type;

   function automatic logic signed [31:0] sat32(input logic signed [81:0] x);
      logic signed [31:0] r;
      if (x > 82'sd2147483647) r = 32'sh7fffffff;
      else if (x < -82'sd2147483648) r = 32'sh80000000;
      else r = x[31:0];
      return r;
   endfunction
endpackage
`default_nettype wire

// File: src/kabf_mul.sv
// Shared rounding multiplier: product of a and b, rounded half up by 16 or 24.
// Depends on kabf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kabf_mul (
   input  wire logic                 clock,
   input  wire kabf_pkg::mul_req_type req,
   output logic signed [81:0]        prod_ff
);
   import kabf_pkg::*;
   logic signed [81:0] full;
   logic signed [81:0] prod_in;
   always_comb begin
      full = 82'(req.a) * 82'(req.b);
      if (req.sh24) prod_in = (full + 82'sd8388608) >>> 24;
      else prod_in = (full + 82'sd32768) >>> 16;
   end
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule
`default_nettype wire

// File: src/kabf_div.sv
// Serial signed divider: (num * 2^24) / den truncated toward zero, one bit a cycle.
// Depends on kabf_pkg.
`timescale 1ns / 1ps
`default_nettype none
module kabf_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic signed [31:0] num,
   input  wire logic signed [33:0] den,
   output logic                    busy_ff,
   output logic signed [31:0]      quot
);
   import kabf_pkg::*;
   logic [56:0] rem_ff, rem_in;
   logic [56:0] q_ff, q_in;
   logic [33:0] d_ff, d_in;
   logic        neg_ff, neg_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_in;
   logic [56:0] trial;
   logic [56:0] nabs;
   logic signed [58:0] qs;
   always_comb begin
      nabs = num[31] ? 57'(-{{25{num[31]}}, num}) : 57'({{25{1'b0}}, num});
      rem_in = rem_ff; q_in = q_ff; d_in = d_ff; neg_in = neg_ff;
      cnt_in = cnt_ff; busy_in = busy_ff;
      trial = {rem_ff[55:0], q_ff[56]};
      if (start) begin
         rem_in = '0;
         q_in = nabs << 24;
         d_in = den[33] ? 34'(-den) : den;
         neg_in = num[31] ^ den[33];
         cnt_in = 6'd57;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= 57'(d_ff)) begin
            rem_in = trial - 57'(d_ff);
            q_in = {q_ff[55:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in = {q_ff[55:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) busy_in = 1'b0;
      end
      qs = neg_ff ? -59'($unsigned(q_ff)) : 59'($unsigned(q_ff));
      quot = sat32(82'(qs));
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in; q_ff <= q_in; d_ff <= d_in; neg_ff <= neg_in;
   end
endmodule
`default_nettype wire

// File: src/kalman_angle_bias_filter_core.sv
// Top level of the two-state angle/bias Kalman filter core.
// Depends on kabf_pkg, kabf_mul, kabf_div and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "kalman_angle_bias_filter_core_defines.svh"
// One transaction in gives one transaction out. A forced load goes from idle
// through the done state to the output register; a filter update runs a
// sequence of steps on one shared multiplier with a registered product, and
// two gain divisions on one bit-serial divider, each followed by a step that
// collects the quotient (both skipped for a zero innovation variance).
// The request side is ready only when idle and the output register is empty
// or being drained. Noise registers are written through the csr channel at
// any time (always ready) and should be changed only while idle. Covariance
// saturates to signed 32 bits; a zero innovation variance yields zero gains
// and gain_fault.
module kalman_angle_bias_filter_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [24:0] measured_angle, [50:25] gyro_rate, [66:51] time_step, 0 fill
   input  wire logic [71:0] req_tdata,
   // [0] force_angle
   input  wire logic        req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [31:0] angle_estimate, [63:32] bias_estimate
   output logic [63:0]      rsp_tdata,
   // [0] gain_fault
   output logic             rsp_tuser,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [31:0] csr_data
);
   import kabf_pkg::*;

   state_type st_ff, st_in;
   logic [23:0] qa_ff, qb_ff, rm_ff;
   logic signed [31:0] ang_ff, ang_in, bias_ff, bias_in;
   logic signed [31:0] p00_ff, p00_in, p01_ff, p01_in, p10_ff, p10_in, p11_ff, p11_in;
   logic signed [24:0] meas_ff;
   logic signed [25:0] rate_ff;
   logic [15:0] dt_ff;
   logic signed [47:0] t_ff, t_in, x_ff, x_in;
   logic signed [31:0] k0_ff, k0_in, k1_ff, k1_in, y_ff, y_in;
   logic fault_ff, fault_in;
   logic ov_ff, ov_in;
   logic [63:0] od_ff, od_in;
   logic ou_ff, ou_in;
   mul_req_type mreq;
   logic signed [81:0] prod;
   logic dstart, dbusy;
   logic signed [31:0] dnum, dq;
   logic signed [33:0] sden;
   logic take;

   assign csr_ready = 1'b1;
   assign req_tready = (st_ff == ST_IDLE) && (!ov_ff || rsp_tready);
   assign take = req_tvalid && req_tready;
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata = od_ff;
   assign rsp_tuser = ou_ff;
   assign sden = 34'(p00_ff) + 34'(rm_ff);

   kabf_mul u_mul (.clock(clock), .req(mreq), .prod_ff(prod));
   kabf_div u_div (.clock(clock), .reset(reset), .start(dstart), .num(dnum),
      .den(sden), .busy_ff(dbusy), .quot(dq));

   // next state
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: if (take) st_in = req_tuser ? ST_DONE : ST_RATE;
         ST_RATE: st_in = ST_ANG;
         ST_ANG: st_in = ST_T;
         ST_T: st_in = ST_INNER;
         ST_INNER: st_in = ST_N00;
         ST_N00: st_in = ST_N11;
         ST_N11: st_in = ST_DIVST;
         ST_DIVST: st_in = (sden == '0) ? ST_Y : ST_DIV0;
         ST_DIV0: if (!dbusy) st_in = ST_DIV1;
         ST_DIV1: if (!dbusy) st_in = ST_Y;
         ST_Y: st_in = ST_CA;
         ST_CA: st_in = ST_CB;
         ST_CB: st_in = ST_C00;
         ST_C00: st_in = ST_C01;
         ST_C01: st_in = ST_C10;
         ST_C10: st_in = ST_C11;
         ST_C11: st_in = ST_DONE;
         ST_DONE: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // datapath and outputs; multiplier product lands in the cycle after issue
   always_comb begin
      ang_in = ang_ff; bias_in = bias_ff;
      p00_in = p00_ff; p01_in = p01_ff; p10_in = p10_ff; p11_in = p11_ff;
      t_in = t_ff; x_in = x_ff; k0_in = k0_ff; k1_in = k1_ff; y_in = y_ff;
      fault_in = fault_ff; ov_in = ov_ff; od_in = od_ff; ou_in = ou_ff;
      mreq = '{a: '0, b: '0, sh24: 1'b0};
      dstart = 1'b0; dnum = p00_ff;
      if (ov_ff && rsp_tready) ov_in = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            fault_in = 1'b0;
            if (take && req_tuser) ang_in = 32'(signed'(req_tdata[24:0]));
         end
         ST_RATE: mreq = '{a: 34'(signed'({1'b0, dt_ff})),
               b: 33'(rate_ff) - 33'(bias_ff), sh24: 1'b0};
         ST_ANG: begin
            ang_in = sat32(82'(ang_ff) + prod);
            mreq = '{a: 34'(signed'({1'b0, dt_ff})), b: 33'(p11_ff), sh24: 1'b0};
         end
         ST_T: begin
            t_in = 48'(prod);
            x_in = 48'(prod) - 48'(p01_ff) - 48'(p10_ff) + 48'(qa_ff);
         end
         ST_INNER: mreq = '{a: 34'(x_ff), b: 33'(signed'({1'b0, dt_ff})), sh24: 1'b0};
         ST_N00: begin
            p00_in = sat32(82'(p00_ff) + prod);
            p01_in = sat32(82'(p01_ff) - 82'(t_ff));
            p10_in = sat32(82'(p10_ff) - 82'(t_ff));
            mreq = '{a: 34'(signed'({1'b0, qb_ff})), b: 33'(signed'({1'b0, dt_ff})),
               sh24: 1'b0};
         end
         ST_N11: p11_in = sat32(82'(p11_ff) + prod);
         ST_DIVST: begin
            k0_in = '0; k1_in = '0;
            if (sden == '0) fault_in = 1'b1;
            else dstart = 1'b1;
         end
         ST_DIV0: if (!dbusy) begin
            k0_in = dq; dnum = p10_ff; dstart = 1'b1;
         end
         ST_DIV1: if (!dbusy) k1_in = dq;
         ST_Y: begin
            y_in = sat32(82'(meas_ff) - 82'(ang_ff));
         end
         ST_CA: mreq = '{a: 34'(k0_ff), b: 33'(y_ff), sh24: 1'b1};
         ST_CB: begin
            ang_in = sat32(82'(ang_ff) + prod);
            mreq = '{a: 34'(k1_ff), b: 33'(y_ff), sh24: 1'b1};
         end
         ST_C00: begin
            bias_in = sat32(82'(bias_ff) + prod);
            mreq = '{a: 34'(k0_ff), b: 33'(p00_ff), sh24: 1'b1};
         end
         ST_C01: begin
            x_in = 48'(sat32(82'(p00_ff) - prod));
            mreq = '{a: 34'(k0_ff), b: 33'(p01_ff), sh24: 1'b1};
         end
         ST_C10: begin
            // new P01 parked in t until the P11 product has read the predicted P01
            t_in = 48'(sat32(82'(p01_ff) - prod));
            mreq = '{a: 34'(k1_ff), b: 33'(p00_ff), sh24: 1'b1};
         end
         ST_C11: begin
            p10_in = sat32(82'(p10_ff) - prod);
            p00_in = x_ff[31:0];
            p01_in = t_ff[31:0];
            mreq = '{a: 34'(k1_ff), b: 33'(p01_ff), sh24: 1'b1};
         end
         ST_DONE: begin
            // in the forced path the multiplier idles, product is unused
            if (!fault_ff && dt_ff == dt_ff && !ou_ff && x_ff == x_ff) begin end
            ov_in = 1'b1;
            od_in = {bias_ff, ang_ff};
            ou_in = fault_ff;
         end
         default: ;
      endcase
   end

   // covariance P11 final update uses the C11 product, in the following cycle
   logic last_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         ov_ff <= 1'b0;
         qa_ff <= AngleNoiseRst; qb_ff <= BiasNoiseRst; rm_ff <= MeasNoiseRst;
         ang_ff <= '0; bias_ff <= '0;
         p00_ff <= '0; p01_ff <= '0; p10_ff <= '0; p11_ff <= '0;
         last_ff <= 1'b0;
         fault_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CsrAngleNoise: qa_ff <= csr_data[23:0];
               CsrBiasNoise: qb_ff <= csr_data[23:0];
               CsrMeasNoise: rm_ff <= csr_data[23:0];
               default: ;
            endcase
         end
         ang_ff <= ang_in; bias_ff <= bias_in;
         p00_ff <= p00_in; p01_ff <= p01_in; p10_ff <= p10_in;
         last_ff <= (st_ff == ST_C11);
         if (last_ff) p11_ff <= sat32(82'(p11_ff) - prod);
         else p11_ff <= p11_in;
         fault_ff <= fault_in;
      end
      if (take) begin
         meas_ff <= req_tdata[24:0];
         rate_ff <= req_tdata[50:25];
         dt_ff <= req_tdata[66:51];
      end
      t_ff <= t_in; x_ff <= x_in; k0_ff <= k0_in; k1_ff <= k1_in; y_ff <= y_in;
      od_ff <= od_in; ou_ff <= ou_in;
   end

   `KABF_ASSERT_SAME(a_no_take_busy, clock, reset, st_ff != ST_IDLE, !req_tready, "ready while busy")
   `KABF_ASSERT_NEXT(a_done_valid, clock, reset, st_ff == ST_DONE, rsp_tvalid, "result lost")
   `KABF_ASSERT_SAME(a_div_idle, clock, reset, st_ff == ST_IDLE, !dbusy, "divider busy when idle")
endmodule
`default_nettype wire
